// ----- rtl/core/tec_pkg.sv -----
// ---------------------------------------------------------------------------
// tec_pkg: shared types and constants for the timestamp event collator
// Holds payload structs, result codes and the sequencer state type.
// ---------------------------------------------------------------------------
package tec_pkg;

   localparam int QUEUE_DEPTH_DEF = 8;
   localparam int MAX_BOARDS_DEF  = 16;
   localparam int MAX_PARTS_DEF   = 64;
   localparam int MAX_RESULTS     = 10;

   localparam int TIME_W  = 63;
   localparam int BOARD_W = 16;
   localparam int PART_W  = 64;
   localparam int CNT_W   = 7;

   localparam logic [31:0] TOL_RESET = 32'd1000000;
   localparam logic [4:0]  EXP_RESET = 5'd16;

   // register indexes
   localparam logic [1:0] REG_TOL  = 2'd0;
   localparam logic [1:0] REG_EXP  = 2'd1;
   localparam logic [1:0] REG_USE  = 2'd2;
   localparam logic [1:0] REG_MASK = 2'd3;

   // result kinds
   localparam logic [1:0] KIND_STATUS     = 2'd0;
   localparam logic [1:0] KIND_COMPLETE   = 2'd1;
   localparam logic [1:0] KIND_INCOMPLETE = 2'd2;
   localparam logic [1:0] KIND_DISCARD    = 2'd3;

   // input status codes
   localparam logic [2:0] ST_NEW    = 3'd0;
   localparam logic [2:0] ST_JOINED = 3'd1;
   localparam logic [2:0] ST_MASKED = 3'd2;
   localparam logic [2:0] ST_LATE   = 3'd3;
   localparam logic [2:0] ST_DUP    = 3'd4;
   localparam logic [2:0] ST_MANY   = 3'd5;

   typedef struct packed {
      logic [3:0]        board_index;
      logic [5:0]        module_number;
      logic [5:0]        block_number;
      logic [6:0]        blocks_per_module;
      logic [6:0]        modules_per_board;
      logic [TIME_W-1:0] packet_time;
   } req_type;

   typedef struct packed {
      logic [1:0]         result_kind;
      logic [2:0]         input_status;
      logic [TIME_W-1:0]  slot_time;
      logic [BOARD_W-1:0] boards_present;
      logic [BOARD_W-1:0] boards_complete;
      logic               last_result;
   } rsp_type;

   // per-cell status toward the sequencer
   typedef struct packed {
      logic              valid;
      logic              match;
      logic              not_later;   // slot time <= packet time
      logic              dup;
      logic [TIME_W-1:0] time_val;
      logic [BOARD_W-1:0] seen;
      logic [BOARD_W-1:0] done;
   } cell_stat_type;

   // commands from the sequencer to every cell
   typedef struct packed {
      logic        shift_up;    // pop: take contents from upper neighbor
      logic        insert;      // open slot at ins_pos, later slots move toward the tail
      logic [5:0]  ins_pos;
      logic        add;         // record packet into slot add_pos
      logic [5:0]  add_pos;
   } cell_cmd_type;

   typedef enum logic [2:0] {
      S_IDLE, S_EVAL, S_ADD, S_STATUS, S_CHECK, S_EMIT
   } seq_state_type;

endpackage

// ----- rtl/core/tec_slot_cell.sv -----
// ---------------------------------------------------------------------------
// tec_slot_cell: one queue slot
// Holds a slot's time, board masks and per-board part bitmaps; moves its
// contents to a neighbor on a pop or an insert.
// ---------------------------------------------------------------------------
module tec_slot_cell
   import tec_pkg::*;
#(
   parameter int MAX_BOARDS = MAX_BOARDS_DEF,
   parameter int MAX_PARTS  = MAX_PARTS_DEF,
   parameter int POS        = 0
) (
   input  logic                      clock,
   input  logic                      reset,
   input  cell_cmd_type              cmd,
   input  logic [TIME_W-1:0]         pkt_time,
   input  logic [3:0]                pkt_board,
   input  logic [5:0]                pkt_idx,
   input  logic [CNT_W-1:0]          pkt_product,
   input  logic [31:0]               tolerance,
   // upper neighbor (toward tail) and lower neighbor (toward head)
   input  logic                      up_valid,
   input  logic [TIME_W-1:0]         up_time,
   input  logic [MAX_BOARDS-1:0]     up_seen,
   input  logic [MAX_BOARDS*MAX_PARTS-1:0] up_parts,
   input  logic [MAX_BOARDS*CNT_W-1:0]     up_exp,
   input  logic                      dn_valid,
   input  logic [TIME_W-1:0]         dn_time,
   input  logic [MAX_BOARDS-1:0]     dn_seen,
   input  logic [MAX_BOARDS*MAX_PARTS-1:0] dn_parts,
   input  logic [MAX_BOARDS*CNT_W-1:0]     dn_exp,
   output logic                      my_valid,
   output logic [TIME_W-1:0]         my_time,
   output logic [MAX_BOARDS-1:0]     my_seen,
   output logic [MAX_BOARDS*MAX_PARTS-1:0] my_parts,
   output logic [MAX_BOARDS*CNT_W-1:0]     my_exp,
   output cell_stat_type             stat
);

   localparam logic [5:0] MY_POS = 6'(POS);

   logic                          valid_ff, valid_in;
   logic [TIME_W-1:0]             time_ff, time_in;
   logic [MAX_BOARDS-1:0]         seen_ff, seen_in;
   logic [MAX_BOARDS*MAX_PARTS-1:0] parts_ff, parts_in;
   logic [MAX_BOARDS*CNT_W-1:0]   exp_ff, exp_in;
   logic [MAX_BOARDS-1:0]         done_w;
   logic [TIME_W-1:0]             diff;
   logic [MAX_PARTS-1:0]          cur_parts;

   // compare and per-board completeness
   always_comb begin
      diff = (pkt_time >= time_ff) ? pkt_time - time_ff : time_ff - pkt_time;
      cur_parts = parts_ff[pkt_board*MAX_PARTS +: MAX_PARTS];
      for (int b = 0; b < MAX_BOARDS; b++) begin
         done_w[b] = seen_ff[b] &&
            (CNT_W'($countones(parts_ff[b*MAX_PARTS +: MAX_PARTS])) ==
             exp_ff[b*CNT_W +: CNT_W]);
      end
      stat.valid     = valid_ff;
      stat.match     = valid_ff && (diff < {31'd0, tolerance});
      stat.not_later = valid_ff && (time_ff <= pkt_time);
      stat.dup       = cur_parts[pkt_idx];
      stat.time_val  = time_ff;
      stat.seen      = BOARD_W'(seen_ff);
      stat.done      = BOARD_W'(done_w);
   end

   // next contents: pop, insert, add
   always_comb begin
      valid_in = valid_ff;
      time_in  = time_ff;
      seen_in  = seen_ff;
      parts_in = parts_ff;
      exp_in   = exp_ff;
      priority if (cmd.shift_up) begin
         valid_in = up_valid;
         time_in  = up_time;
         seen_in  = up_seen;
         parts_in = up_parts;
         exp_in   = up_exp;
      end else if (cmd.insert && MY_POS > cmd.ins_pos) begin
         valid_in = dn_valid;
         time_in  = dn_time;
         seen_in  = dn_seen;
         parts_in = dn_parts;
         exp_in   = dn_exp;
      end else if (cmd.insert && MY_POS == cmd.ins_pos) begin
         valid_in = 1'b1;
         time_in  = pkt_time;
         seen_in  = '0;
         parts_in = '0;
         exp_in   = '0;
      end else if (cmd.add && MY_POS == cmd.add_pos) begin
         seen_in[pkt_board] = 1'b1;
         parts_in[pkt_board*MAX_PARTS + 32'(pkt_idx)] = 1'b1;
         exp_in[pkt_board*CNT_W +: CNT_W] = pkt_product;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         seen_ff  <= '0;
         parts_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         seen_ff  <= seen_in;
         parts_ff <= parts_in;
      end
      time_ff <= time_in;
      exp_ff  <= exp_in;
   end

   assign my_valid = valid_ff;
   assign my_time  = time_ff;
   assign my_seen  = seen_ff;
   assign my_parts = parts_ff;
   assign my_exp   = exp_ff;

endmodule

// ----- rtl/core/tec_sequencer.sv -----
// ---------------------------------------------------------------------------
// tec_sequencer: transaction control
// Classifies a packet from the cell row, issues insert/add/pop commands and
// produces the result sequence.
// ---------------------------------------------------------------------------
module tec_sequencer
   import tec_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
   parameter int MAX_BOARDS  = MAX_BOARDS_DEF,
   parameter int MAX_PARTS   = MAX_PARTS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic [4:0]           expected_boards,
   input  logic                 use_board_list,
   input  logic [15:0]          board_enable_mask,
   input  cell_stat_type        stat [QUEUE_DEPTH],
   output cell_cmd_type         cmd,
   output req_type              pkt
);

   seq_state_type state_ff, state_in;
   req_type       pkt_ff;
   logic [2:0]    status_ff, status_in;
   logic [5:0]    pos_ff, pos_in;
   logic [3:0]    nres_ff, nres_in;
   logic [1:0]    emit_cnt_ff, emit_cnt_in;
   logic [TIME_W-1:0] last_ff, last_in;
   rsp_type       out_ff, out_in;
   logic          out_vld_ff, out_vld_in;
   logic          rejected;
   logic          any_match, full_q;
   logic [5:0]    match_pos, ins_pos;
   logic [13:0]   product_w, idx_w;
   logic          head_complete;
   logic          out_free;

   assign product_w = 14'(req_data.modules_per_board) * 14'(req_data.blocks_per_module);
   assign idx_w     = 14'(req_data.module_number) * 14'(req_data.blocks_per_module)
                      + 14'(req_data.block_number);

   // scan the cell row: first matching slot and insert position
   always_comb begin
      any_match = 1'b0;
      match_pos = '0;
      ins_pos   = '0;
      for (int s = QUEUE_DEPTH-1; s >= 0; s--) begin
         if (stat[s].match) begin
            any_match = 1'b1;
            match_pos = 6'(s);
         end
      end
      for (int s = 0; s < QUEUE_DEPTH; s++) begin
         if (stat[s].not_later) ins_pos = 6'(s + 1);
      end
      full_q = stat[QUEUE_DEPTH-1].valid;
      head_complete = stat[0].valid &&
         (5'($countones(stat[0].seen)) == expected_boards) &&
         (stat[0].done == stat[0].seen);
   end

   assign out_free  = !out_vld_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rejected  = (7'(req_data.board_index) >= 7'(MAX_BOARDS)) ||
                      (use_board_list && !board_enable_mask[req_data.board_index]);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (req_valid) state_in = S_EVAL;
         S_EVAL:   state_in = (status_in <= ST_JOINED) ? S_ADD : S_STATUS;
         S_ADD:    state_in = S_STATUS;
         S_STATUS: if (out_free) state_in = (status_ff <= ST_JOINED) ? S_CHECK : S_IDLE;
         S_CHECK:  if (out_free) state_in = (head_complete && nres_ff < 4'(MAX_RESULTS) ||
                     full_q && nres_ff < 4'(MAX_RESULTS)) ? S_EMIT : S_IDLE;
         // a forced-out head ends the sequence
         S_EMIT:   state_in = (out_ff.result_kind == KIND_COMPLETE) ? S_CHECK : S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      status_in   = status_ff;
      pos_in      = pos_ff;
      nres_in     = nres_ff;
      emit_cnt_in = emit_cnt_ff;
      last_in     = last_ff;
      out_in      = out_ff;
      out_vld_in  = out_vld_ff && rsp_stall;
      cmd         = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               nres_in = 4'd1;
               if (rejected) status_in = ST_MASKED;
               else if (product_w > 14'(MAX_PARTS) || idx_w >= 14'(MAX_PARTS))
                  status_in = ST_MANY;
               else status_in = ST_NEW;
            end
         end
         S_EVAL: begin
            if (status_ff == ST_NEW) begin
               if (any_match) begin
                  pos_in    = match_pos;
                  status_in = stat[match_pos[$clog2(QUEUE_DEPTH)-1:0]].dup ?
                              ST_DUP : ST_JOINED;
               end else if (pkt_ff.packet_time < last_ff) begin
                  status_in = ST_LATE;
               end else begin
                  pos_in     = ins_pos;
                  cmd.insert = 1'b1;
                  cmd.ins_pos = ins_pos;
               end
            end
         end
         S_ADD: begin
            cmd.add     = 1'b1;
            cmd.add_pos = pos_ff;
         end
         S_STATUS: begin
            if (out_free) begin
               out_vld_in = 1'b1;
               out_in     = '0;
               out_in.input_status = status_ff;
               if (status_ff <= ST_JOINED) begin
                  out_in.slot_time       = stat[pos_ff[$clog2(QUEUE_DEPTH)-1:0]].time_val;
                  out_in.boards_present  = stat[pos_ff[$clog2(QUEUE_DEPTH)-1:0]].seen;
                  out_in.boards_complete = stat[pos_ff[$clog2(QUEUE_DEPTH)-1:0]].done;
                  out_in.last_result = !((head_complete || full_q));
               end else begin
                  out_in.last_result = 1'b1;
               end
            end
         end
         S_CHECK: begin
            if (out_free && nres_ff < 4'(MAX_RESULTS) && (head_complete || full_q)) begin
               out_vld_in = 1'b1;
               out_in     = '0;
               out_in.slot_time      = stat[0].time_val;
               out_in.boards_present = stat[0].seen;
               if (head_complete) begin
                  out_in.result_kind     = KIND_COMPLETE;
                  out_in.boards_complete = stat[0].seen;
                  last_in = stat[0].time_val;
               end else begin
                  out_in.boards_complete = stat[0].done;
                  if (emit_cnt_ff > 2'd1) begin
                     out_in.result_kind = KIND_INCOMPLETE;
                     last_in = stat[0].time_val;
                  end else begin
                     out_in.result_kind = KIND_DISCARD;
                  end
               end
               // last if forced out or at the result limit; EMIT rechecks a complete pop
               out_in.last_result = !head_complete || nres_ff + 4'd1 >= 4'(MAX_RESULTS);
               cmd.shift_up = 1'b1;
               nres_in = nres_ff + 4'd1;
               if (emit_cnt_ff < 2'd2) emit_cnt_in = emit_cnt_ff + 2'd1;
            end
         end
         S_EMIT: begin
            // hold the result while the popped queue settles
            out_vld_in = out_vld_ff;
            // after a complete pop, the next head may also leave; mark last if not
            if (out_vld_ff && out_ff.result_kind == KIND_COMPLETE && !out_ff.last_result &&
                !(head_complete || full_q)) begin
               out_in.last_result = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         out_vld_ff  <= 1'b0;
         emit_cnt_ff <= '0;
         last_ff     <= '0;
      end else begin
         state_ff    <= state_in;
         out_vld_ff  <= out_vld_in;
         emit_cnt_ff <= emit_cnt_in;
         last_ff     <= last_in;
      end
      status_ff <= status_in;
      pos_ff    <= pos_in;
      nres_ff   <= nres_in;
      out_ff    <= out_in;
      if (state_ff == S_IDLE && req_valid) pkt_ff <= req_data;
   end

   assign rsp_valid = out_vld_ff && !(state_ff == S_EMIT);
   assign rsp_data  = out_ff;
   assign pkt       = pkt_ff;

endmodule

// ----- rtl/core/timestamp_event_collator_unit.sv -----
// ---------------------------------------------------------------------------
// timestamp_event_collator_unit: time-slot collator
// Sorted queue of slot cells plus a sequencer that classifies packets and
// emits finished or forced-out slots.
// ---------------------------------------------------------------------------
// channel  dir  handshake       payload
// req_     in   valid / stall   req_type
// rsp_     out  valid / stall   rsp_type
// csr_     in   valid / ready   index, write data
//
// A rejected packet passes the IDLE, EVAL and STATUS states and a recorded one
// also ADD and CHECK; each complete slot that leaves the queue adds an EMIT and
// a CHECK step, and a head that a full queue forces out adds a last EMIT.
// Reset is synchronous and clears queue, last emitted time and the emit counter.
// A stall on rsp_ holds the result register and pauses the sequencer in STATUS and CHECK.
// ---------------------------------------------------------------------------
module timestamp_event_collator_unit
   import tec_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
   parameter int MAX_BOARDS  = MAX_BOARDS_DEF,
   parameter int MAX_PARTS   = MAX_PARTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int PW = MAX_BOARDS * MAX_PARTS;
   localparam int EW = MAX_BOARDS * CNT_W;

   logic [31:0] tol_ff;
   logic [4:0]  exp_ff;
   logic        use_ff;
   logic [15:0] mask_ff;

   cell_cmd_type  cmd;
   cell_stat_type stat [QUEUE_DEPTH];
   req_type       pkt;

   logic              c_valid [QUEUE_DEPTH+1];
   logic [TIME_W-1:0] c_time  [QUEUE_DEPTH+1];
   logic [MAX_BOARDS-1:0] c_seen [QUEUE_DEPTH+1];
   logic [PW-1:0]     c_parts [QUEUE_DEPTH+1];
   logic [EW-1:0]     c_exp   [QUEUE_DEPTH+1];

   // configuration registers
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff  <= TOL_RESET;
         exp_ff  <= EXP_RESET;
         use_ff  <= 1'b0;
         mask_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_TOL:  tol_ff  <= csr_wdata;
            REG_EXP:  exp_ff  <= csr_wdata[4:0];
            REG_USE:  use_ff  <= csr_wdata[0];
            REG_MASK: mask_ff <= csr_wdata[15:0];
            default:  ;
         endcase
      end
   end

   // empty cell beyond the tail
   assign c_valid[QUEUE_DEPTH] = 1'b0;
   assign c_time[QUEUE_DEPTH]  = '0;
   assign c_seen[QUEUE_DEPTH]  = '0;
   assign c_parts[QUEUE_DEPTH] = '0;
   assign c_exp[QUEUE_DEPTH]   = '0;

   for (genvar s = 0; s < QUEUE_DEPTH; s++) begin : g_cell
      tec_slot_cell #(.MAX_BOARDS(MAX_BOARDS), .MAX_PARTS(MAX_PARTS), .POS(s)) u_cell (
         .clock, .reset, .cmd,
         .pkt_time    (pkt.packet_time),
         .pkt_board   (pkt.board_index),
         .pkt_idx     (6'(pkt.module_number * 6'(pkt.blocks_per_module)
                         + pkt.block_number)),
         .pkt_product (CNT_W'(pkt.modules_per_board * pkt.blocks_per_module)),
         .tolerance   (tol_ff),
         .up_valid    (c_valid[s+1]), .up_time (c_time[s+1]), .up_seen (c_seen[s+1]),
         .up_parts    (c_parts[s+1]), .up_exp  (c_exp[s+1]),
         .dn_valid    (c_valid[(s>0)?s-1:0]), .dn_time (c_time[(s>0)?s-1:0]),
         .dn_seen     (c_seen[(s>0)?s-1:0]), .dn_parts (c_parts[(s>0)?s-1:0]),
         .dn_exp      (c_exp[(s>0)?s-1:0]),
         .my_valid    (c_valid[s]), .my_time (c_time[s]), .my_seen (c_seen[s]),
         .my_parts    (c_parts[s]), .my_exp  (c_exp[s]),
         .stat        (stat[s])
      );
   end

   tec_sequencer #(.QUEUE_DEPTH(QUEUE_DEPTH), .MAX_BOARDS(MAX_BOARDS),
                   .MAX_PARTS(MAX_PARTS)) u_seq (
      .clock, .reset,
      .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data,
      .expected_boards   (exp_ff),
      .use_board_list    (use_ff),
      .board_enable_mask (mask_ff),
      .stat, .cmd, .pkt
   );

endmodule
